### design/tbqn_pkg.sv
// ----------------------------------------------------------------------------
// tbqn_pkg
// Shared constants and types of the two-body quantum number enumerator.
// ----------------------------------------------------------------------------
`default_nettype none
package tbqn_pkg;
  localparam int MAX_STATES = 256;
  localparam int ADDR_W     = $clog2(MAX_STATES);
  localparam int CNT_W      = $clog2(MAX_STATES + 1);
  localparam int ENTRY_W    = 16;

  localparam logic [1:0] OP_RESTART = 2'd0;
  localparam logic [1:0] OP_NEXT    = 2'd1;
  localparam logic [1:0] OP_LOOKUP  = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [2:0] ST_TUPLE     = 3'd0;
  localparam logic [2:0] ST_EXHAUSTED = 3'd1;
  localparam logic [2:0] ST_BUILT     = 3'd2;
  localparam logic [2:0] ST_ENTRY     = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;

  localparam logic [1:0] REG_SHELL  = 2'd0;
  localparam logic [1:0] REG_RADIAL = 2'd1;
  localparam logic [1:0] REG_ORBIT  = 2'd2;
  localparam logic [1:0] REG_PAIR   = 2'd3;

  // one single-particle state as stored in the table memory
  typedef struct packed {
    logic [4:0] shell;
    logic [4:0] orbital;
    logic [5:0] twice_j;
  } entry_t;
endpackage
`default_nettype wire

### design/tbqn_if.sv
// ----------------------------------------------------------------------------
// tbqn_cmd_if / tbqn_rsp_if
// Valid/ready channels for command words and response words.
// ----------------------------------------------------------------------------
`default_nettype none
interface tbqn_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] state_index;
  modport source (output valid, output operation, output state_index, input ready);
  modport sink   (input valid, input operation, input state_index, output ready);
endinterface

interface tbqn_rsp_if;
  logic              valid;
  logic              ready;
  logic [7:0]        first_bra;
  logic [7:0]        second_bra;
  logic [7:0]        first_ket;
  logic [7:0]        second_ket;
  logic [5:0]        total_j;
  logic              isospin;
  logic signed [1:0] isospin_proj;
  logic [3:0]        radial_n;
  logic [4:0]        orbital_l;
  logic [5:0]        twice_j;
  logic [8:0]        state_count;
  logic [2:0]        status;
  modport source (output valid, output first_bra, output second_bra, output first_ket,
                  output second_ket, output total_j, output isospin, output isospin_proj,
                  output radial_n, output orbital_l, output twice_j, output state_count,
                  output status, input ready);
  modport sink   (input valid, input first_bra, input second_bra, input first_ket,
                  input second_ket, input total_j, input isospin, input isospin_proj,
                  input radial_n, input orbital_l, input twice_j, input state_count,
                  input status, output ready);
endinterface
`default_nettype wire

### design/tbqn_ram.sv
// ----------------------------------------------------------------------------
// tbqn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tbqn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### design/two_body_quantum_number_enumerator.sv
// ----------------------------------------------------------------------------
// two_body_quantum_number_enumerator
// Builds the single-particle state table and walks two-body tuples from it.
// ----------------------------------------------------------------------------
//  channel | dir | words
//  cmd     | in  | operation, state_index
//  rsp     | out | tuple, status, state entry, state_count
//  cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
//  One command word at a time; the next is taken once the response is gone.
//  Restart: the table walk steps through each candidate (shell, l, j), each
//  (shell, l) beyond the radial limit and each shell, then the seek runs.
//  Next: the seek reads the table memory for each reloaded entry and checks
//  each candidate; the single read port of the table memory sets its pace.
//  Lookup: one table memory read. Reset is synchronous and leaves the walk exhausted.
`default_nettype none
module two_body_quantum_number_enumerator (
  input  wire logic       clk,
  input  wire logic       rst,
  tbqn_cmd_if.sink        cmd,
  tbqn_rsp_if.source      rsp,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [5:0] cfg_data
);
  typedef enum logic [2:0] {
    S_IDLE, S_BUILD, S_LD_ISSUE, S_LD_WAIT, S_EVAL, S_LOOK, S_LOOK_WAIT
  } state_t;

  localparam int AW = tbqn_pkg::ADDR_W;
  localparam int CW = tbqn_pkg::CNT_W;

  state_t state;
  logic [4:0] shell_max;
  logic [3:0] radial_max;
  logic [4:0] orbital_max;
  logic [5:0] pair_energy_max;

  logic [CW-1:0] table_size;
  logic [CW-1:0] cnt [4];          // bra1, bra2, ket1, ket2
  logic [6:0]    j_ctr;
  logic [1:0]    iso_ctr;
  logic          walk_done;
  logic [3:0]    reload;
  logic [1:0]    sel;
  tbqn_pkg::entry_t slot [4];

  logic [5:0] e_q;
  logic [5:0] l_q;
  logic       jsel;
  logic [7:0] look_idx;
  logic       rsp_valid;

  // table memory
  logic             ram_we;
  logic [AW-1:0]    ram_raddr;
  tbqn_pkg::entry_t ram_wdata;
  logic [tbqn_pkg::ENTRY_W-1:0] ram_rdata;
  tbqn_pkg::entry_t rd_entry;

  tbqn_ram #(.WIDTH(tbqn_pkg::ENTRY_W), .DEPTH(tbqn_pkg::MAX_STATES)) u_table (
    .clk(clk), .we(ram_we), .waddr(table_size[AW-1:0]), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign rd_entry = ram_rdata;

  // build step
  logic       l_ok;
  logic [5:0] n_val;
  logic       n_ok;
  logic       room;
  always_comb begin
    l_ok  = (l_q <= e_q) && (l_q <= {1'b0, orbital_max});
    n_val = (e_q - l_q) >> 1;
    n_ok  = n_val <= {2'b00, radial_max};
    room  = table_size < CW'(tbqn_pkg::MAX_STATES);
    ram_wdata.shell   = e_q[4:0];
    ram_wdata.orbital = l_q[4:0];
    if (l_q == 6'd0) begin
      ram_wdata.twice_j = 6'd1;
    end else if (jsel) begin
      ram_wdata.twice_j = {l_q[4:0], 1'b1};
    end else begin
      ram_wdata.twice_j = {l_q[4:0], 1'b0} - 6'd1;
    end
    ram_we = (state == S_BUILD) && (e_q <= {1'b0, shell_max}) && l_ok && n_ok && room;
  end

  // read address and first pending reload
  logic [1:0] pick;
  always_comb begin
    if (reload[0]) begin
      pick = 2'd0;
    end else if (reload[1]) begin
      pick = 2'd1;
    end else if (reload[2]) begin
      pick = 2'd2;
    end else begin
      pick = 2'd3;
    end
    if (state == S_LOOK) begin
      ram_raddr = look_idx[AW-1:0];
    end else begin
      ram_raddr = cnt[pick][AW-1:0];
    end
  end

  // seek evaluation on the cached entries
  logic       pair_ab;
  logic       pair_cd;
  logic       odd_l;
  logic [CW-1:0] kmax;
  logic [5:0] lo1, lo2, lo;
  logic [6:0] hi1, hi2;
  logic [6:0] lo_j, hi_j, j_new;
  always_comb begin
    pair_ab = ({1'b0, slot[0].shell} + {1'b0, slot[1].shell}) <= pair_energy_max;
    pair_cd = ({1'b0, slot[2].shell} + {1'b0, slot[3].shell}) <= pair_energy_max;
    odd_l   = slot[0].orbital[0] ^ slot[1].orbital[0] ^ slot[2].orbital[0]
              ^ slot[3].orbital[0];
    kmax    = (cnt[2] == cnt[0]) ? cnt[1] : cnt[2];
    lo1 = (slot[0].twice_j > slot[1].twice_j) ? slot[0].twice_j - slot[1].twice_j
                                              : slot[1].twice_j - slot[0].twice_j;
    lo2 = (slot[2].twice_j > slot[3].twice_j) ? slot[2].twice_j - slot[3].twice_j
                                              : slot[3].twice_j - slot[2].twice_j;
    lo  = (lo1 > lo2) ? lo1 : lo2;
    hi1 = {1'b0, slot[0].twice_j} + {1'b0, slot[1].twice_j};
    hi2 = {1'b0, slot[2].twice_j} + {1'b0, slot[3].twice_j};
    lo_j = {2'b00, lo[5:1]};
    hi_j = ((hi1 < hi2) ? hi1 : hi2) >> 1;
    j_new = (j_ctr < lo_j) ? lo_j : j_ctr;
  end

  assign cmd.ready = (state == S_IDLE) && !rsp_valid;
  assign rsp.valid = rsp_valid;
  assign rsp.state_count = table_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      shell_max       <= 5'd4;
      radial_max      <= 4'd15;
      orbital_max     <= 5'd31;
      pair_energy_max <= 6'd63;
      table_size      <= '0;
      for (int i = 0; i < 4; i++) begin
        cnt[i] <= '0;
      end
      j_ctr     <= '0;
      iso_ctr   <= '0;
      walk_done <= 1'b1;
      reload    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tbqn_pkg::REG_SHELL:  shell_max       <= cfg_data[4:0];
          tbqn_pkg::REG_RADIAL: radial_max      <= cfg_data[3:0];
          tbqn_pkg::REG_ORBIT:  orbital_max     <= cfg_data[4:0];
          tbqn_pkg::REG_PAIR:   pair_energy_max <= cfg_data;
          default: ;
        endcase
      end
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid && cmd.ready && cmd.operation != tbqn_pkg::OP_UNUSED) begin
            rsp.first_bra    <= '0;
            rsp.second_bra   <= '0;
            rsp.first_ket    <= '0;
            rsp.second_ket   <= '0;
            rsp.total_j      <= '0;
            rsp.isospin      <= 1'b0;
            rsp.isospin_proj <= '0;
            rsp.radial_n     <= '0;
            rsp.orbital_l    <= '0;
            rsp.twice_j      <= '0;
            look_idx         <= cmd.state_index;
            case (cmd.operation)
              tbqn_pkg::OP_RESTART: begin
                rsp.status <= tbqn_pkg::ST_BUILT;
                table_size <= '0;
                e_q        <= '0;
                l_q        <= '0;
                jsel       <= 1'b0;
                state      <= S_BUILD;
              end
              tbqn_pkg::OP_NEXT: begin
                if (walk_done) begin
                  rsp.status <= tbqn_pkg::ST_EXHAUSTED;
                  rsp_valid  <= 1'b1;
                end else begin
                  rsp.status       <= tbqn_pkg::ST_TUPLE;
                  rsp.first_bra    <= cnt[0][7:0];
                  rsp.second_bra   <= cnt[1][7:0];
                  rsp.first_ket    <= cnt[2][7:0];
                  rsp.second_ket   <= cnt[3][7:0];
                  rsp.total_j      <= j_ctr[5:0];
                  rsp.isospin      <= (iso_ctr != 2'd0);
                  rsp.isospin_proj <= (iso_ctr == 2'd1) ? 2'sb11 :
                                      (iso_ctr == 2'd3) ? 2'sb01 : 2'sb00;
                  iso_ctr <= iso_ctr + 2'd1;
                  if (iso_ctr == 2'd3) begin
                    j_ctr <= j_ctr + 7'd1;
                  end
                  state <= S_EVAL;
                end
              end
              default: begin
                if ({1'b0, cmd.state_index} < table_size
                    && CW'(cmd.state_index) < CW'(tbqn_pkg::MAX_STATES)) begin
                  state <= S_LOOK;
                end else begin
                  rsp.status <= tbqn_pkg::ST_RANGE;
                  rsp_valid  <= 1'b1;
                end
              end
            endcase
          end
        end
        S_BUILD: begin
          if (e_q > {1'b0, shell_max}) begin
            for (int i = 0; i < 4; i++) begin
              cnt[i] <= '0;
            end
            j_ctr     <= '0;
            iso_ctr   <= '0;
            walk_done <= 1'b0;
            reload    <= 4'b1111;
            state     <= S_LD_ISSUE;
          end else if (l_ok) begin
            if (ram_we) begin
              table_size <= table_size + CW'(1);
            end
            if (n_ok && l_q != 6'd0 && !jsel) begin
              jsel <= 1'b1;
            end else begin
              jsel <= 1'b0;
              l_q  <= l_q + 6'd2;
            end
          end else begin
            e_q  <= e_q + 6'd1;
            l_q  <= {5'd0, ~e_q[0]};
            jsel <= 1'b0;
          end
        end
        S_LD_ISSUE: begin
          sel   <= pick;
          state <= S_LD_WAIT;
        end
        S_LD_WAIT: begin
          slot[sel]   <= rd_entry;
          reload[sel] <= 1'b0;
          state       <= ((reload & ~(4'b0001 << sel)) == 4'b0000) ? S_EVAL : S_LD_ISSUE;
        end
        S_EVAL: begin
          if (cnt[0] >= table_size) begin
            walk_done <= 1'b1;
            state     <= S_IDLE;
            rsp_valid <= 1'b1;
          end else if (cnt[1] > cnt[0]) begin
            cnt[0]  <= cnt[0] + CW'(1);
            cnt[1]  <= '0;
            cnt[2]  <= '0;
            cnt[3]  <= '0;
            j_ctr   <= '0;
            iso_ctr <= '0;
            reload  <= 4'b1111;
            state   <= S_LD_ISSUE;
          end else if (!pair_ab || cnt[2] > cnt[0]) begin
            cnt[1]  <= cnt[1] + CW'(1);
            cnt[2]  <= '0;
            cnt[3]  <= '0;
            j_ctr   <= '0;
            iso_ctr <= '0;
            reload  <= 4'b1110;
            state   <= S_LD_ISSUE;
          end else if (cnt[3] > kmax) begin
            cnt[2]  <= cnt[2] + CW'(1);
            cnt[3]  <= '0;
            j_ctr   <= '0;
            iso_ctr <= '0;
            reload  <= 4'b1100;
            state   <= S_LD_ISSUE;
          end else if (!pair_cd || odd_l || j_new > hi_j) begin
            // drop this ket pair and fetch the next second ket
            cnt[3]  <= cnt[3] + CW'(1);
            j_ctr   <= '0;
            iso_ctr <= '0;
            reload  <= 4'b1000;
            state   <= S_LD_ISSUE;
          end else begin
            j_ctr     <= j_new;
            state     <= S_IDLE;
            rsp_valid <= 1'b1;
          end
        end
        S_LOOK: begin
          state <= S_LOOK_WAIT;
        end
        S_LOOK_WAIT: begin
          rsp.radial_n  <= 4'((rd_entry.shell - rd_entry.orbital) >> 1);
          rsp.orbital_l <= rd_entry.orbital;
          rsp.twice_j   <= rd_entry.twice_j;
          rsp.status    <= tbqn_pkg::ST_ENTRY;
          rsp_valid     <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/tbqn_checker.sv
// ----------------------------------------------------------------------------
// tbqn_checker
// Port-level checks of the enumerator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module tbqn_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       rsp_valid,
  input wire logic       rsp_ready,
  input wire logic [7:0] first_bra,
  input wire logic [7:0] second_bra,
  input wire logic [5:0] total_j,
  input wire logic [5:0] twice_j,
  input wire logic [8:0] state_count,
  input wire logic [2:0] status
);
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> status <= tbqn_pkg::ST_RANGE)
    else $error("bad status code");

  a_exhausted_clear: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == tbqn_pkg::ST_EXHAUSTED |->
      first_bra == 8'd0 && total_j == 6'd0)
    else $error("exhausted word carries tuple data");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == tbqn_pkg::ST_TUPLE |-> second_bra <= first_bra)
    else $error("second bra above first bra");

  a_entry_odd: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == tbqn_pkg::ST_ENTRY |-> twice_j[0] && state_count != 9'd0)
    else $error("state entry with even twice j");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
    else $error("response dropped while stalled");
endmodule

bind two_body_quantum_number_enumerator tbqn_checker u_tbqn_checker (
  .clk(clk), .rst(rst), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .first_bra(rsp.first_bra), .second_bra(rsp.second_bra), .total_j(rsp.total_j),
  .twice_j(rsp.twice_j), .state_count(rsp.state_count), .status(rsp.status)
);
`default_nettype wire

### tb/tb_two_body_quantum_number_enumerator.sv
// ----------------------------------------------------------------------------
// tb_two_body_quantum_number_enumerator
// Checks the state table, the lookup and the two-body tuple walk against a
// behavioral predictor. A short table of directed words runs first, then
// random command words under three idle patterns, with register writes
// between rounds while the block is quiet.
// ----------------------------------------------------------------------------
module tb_two_body_quantum_number_enumerator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 40;

  typedef struct packed {
    logic [7:0]        first_bra;
    logic [7:0]        second_bra;
    logic [7:0]        first_ket;
    logic [7:0]        second_ket;
    logic [5:0]        total_j;
    logic              isospin;
    logic signed [1:0] isospin_proj;
    logic [3:0]        radial_n;
    logic [4:0]        orbital_l;
    logic [5:0]        twice_j;
    logic [8:0]        state_count;
    logic [2:0]        status;
  } tuple_word_t;

  typedef struct {
    bit         is_cfg;
    logic [1:0] code;   // operation, or register index for a write
    logic [7:0] arg;    // state index, or write data
    int         reps;
    bit         known;
    logic [2:0] want_status;
    logic [8:0] want_count;
  } row_t;

  logic clk;
  logic rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [5:0] cfg_data;

  tbqn_cmd_if cmd ();
  tbqn_rsp_if rsp ();

  two_body_quantum_number_enumerator dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd.sink),
    .rsp       (rsp.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic [4:0] shell_of [tbqn_pkg::MAX_STATES];
  logic [4:0] orbit_of [tbqn_pkg::MAX_STATES];
  logic [5:0] tj_of    [tbqn_pkg::MAX_STATES];
  int n_states;
  int b1, b2, k1, k2, jv, iso_step;
  bit walk_over;
  int lim_shell, lim_radial, lim_orbit, lim_pair;

  tuple_word_t pending_words[$];
  int errors;
  int cycles;
  int src_idle, snk_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("two_body_quantum_number_enumerator verification failed");
      $finish;
    end
  end

  function automatic void rebuild_states();
    int e, l, tj, lo, n;
    n = 0;
    for (e = 0; e <= lim_shell; e++) begin
      for (l = e % 2; l <= e && l <= lim_orbit; l += 2) begin
        if ((e - l) / 2 > lim_radial) continue;
        lo = (l == 0) ? 1 : 2 * l - 1;
        for (tj = lo; tj <= 2 * l + 1; tj += 2) begin
          if (n < tbqn_pkg::MAX_STATES) begin
            shell_of[n] = 5'(e);
            orbit_of[n] = 5'(l);
            tj_of[n]    = 6'(tj);
            n++;
          end
        end
      end
    end
    n_states = n;
  endfunction

  function automatic bit pair_fits(int x, int y);
    return int'(shell_of[x]) + int'(shell_of[y]) <= lim_pair;
  endfunction

  // advance to the first legal tuple at or after the current position
  function automatic void advance_walk();
    int kmax, a, b, c, d, lo1, lo2, lo, hi;
    while (!walk_over) begin
      if (b1 >= n_states) begin
        walk_over = 1'b1;
        return;
      end
      if (b2 > b1) begin
        b1++; b2 = 0; k1 = 0; k2 = 0; jv = 0; iso_step = 0;
        continue;
      end
      if (!pair_fits(b1, b2) || k1 > b1) begin
        b2++; k1 = 0; k2 = 0; jv = 0; iso_step = 0;
        continue;
      end
      kmax = (k1 == b1) ? b2 : k1;
      if (k2 > kmax) begin
        k1++; k2 = 0; jv = 0; iso_step = 0;
        continue;
      end
      if (!pair_fits(k1, k2) ||
          ((orbit_of[b1] + orbit_of[b2] + orbit_of[k1] + orbit_of[k2]) % 2 != 0)) begin
        k2++; jv = 0; iso_step = 0;
        continue;
      end
      a = tj_of[b1]; b = tj_of[b2]; c = tj_of[k1]; d = tj_of[k2];
      lo1 = (a > b) ? a - b : b - a;
      lo2 = (c > d) ? c - d : d - c;
      lo  = ((lo1 > lo2) ? lo1 : lo2) / 2;
      hi  = (((a + b) < (c + d)) ? a + b : c + d) / 2;
      if (jv < lo) jv = lo;
      if (jv > hi) begin
        k2++; jv = 0; iso_step = 0;
        continue;
      end
      return;
    end
  endfunction

  function automatic bit predict_word(logic [1:0] op, logic [7:0] idx,
                                      output tuple_word_t w);
    w = '0;
    if (op != tbqn_pkg::OP_RESTART && op != tbqn_pkg::OP_NEXT
        && op != tbqn_pkg::OP_LOOKUP) return 1'b0;
    if (op == tbqn_pkg::OP_RESTART) begin
      rebuild_states();
      b1 = 0; b2 = 0; k1 = 0; k2 = 0; jv = 0; iso_step = 0;
      walk_over = 1'b0;
      advance_walk();
      w.status = tbqn_pkg::ST_BUILT;
    end else if (op == tbqn_pkg::OP_NEXT) begin
      if (walk_over) begin
        w.status = tbqn_pkg::ST_EXHAUSTED;
      end else begin
        w.first_bra  = 8'(b1);
        w.second_bra = 8'(b2);
        w.first_ket  = 8'(k1);
        w.second_ket = 8'(k2);
        w.total_j    = 6'(jv);
        // isospin order: (0,0) (1,-1) (1,0) (1,1)
        w.isospin      = (iso_step != 0);
        w.isospin_proj = (iso_step == 0) ? 2'sd0 : 2'(iso_step - 2);
        w.status       = tbqn_pkg::ST_TUPLE;
        iso_step++;
        if (iso_step > 3) begin
          iso_step = 0;
          jv++;
        end
        advance_walk();
      end
    end else begin
      if (int'(idx) < n_states) begin
        w.radial_n  = 4'((shell_of[idx] - orbit_of[idx]) >> 1);
        w.orbital_l = orbit_of[idx];
        w.twice_j   = tj_of[idx];
        w.status    = tbqn_pkg::ST_ENTRY;
      end else begin
        w.status = tbqn_pkg::ST_RANGE;
      end
    end
    w.state_count = 9'(n_states);
    return 1'b1;
  endfunction

  task automatic report_field(string name, logic [8:0] got, logic [8:0] want);
    if (got !== want) begin
      $display("mismatch at %0d: %s got %0h want %0h", cycles, name, got, want);
      errors++;
    end
  endtask

  // response side: random stall, compare each word with the oldest expectation
  always @(posedge clk) begin
    tuple_word_t w;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= snk_idle);
      if (rsp.valid && rsp.ready) begin
        if (pending_words.size() == 0) begin
          $display("mismatch at %0d: unexpected response word", cycles);
          errors++;
        end else begin
          w = pending_words.pop_front();
          report_field("first_bra", 9'(rsp.first_bra), 9'(w.first_bra));
          report_field("second_bra", 9'(rsp.second_bra), 9'(w.second_bra));
          report_field("first_ket", 9'(rsp.first_ket), 9'(w.first_ket));
          report_field("second_ket", 9'(rsp.second_ket), 9'(w.second_ket));
          report_field("total_j", 9'(rsp.total_j), 9'(w.total_j));
          report_field("isospin", 9'(rsp.isospin), 9'(w.isospin));
          report_field("isospin_proj", {7'd0, $unsigned(rsp.isospin_proj)},
                       {7'd0, $unsigned(w.isospin_proj)});
          report_field("radial_n", 9'(rsp.radial_n), 9'(w.radial_n));
          report_field("orbital_l", 9'(rsp.orbital_l), 9'(w.orbital_l));
          report_field("twice_j", 9'(rsp.twice_j), 9'(w.twice_j));
          report_field("state_count", rsp.state_count, w.state_count);
          report_field("status", 9'(rsp.status), 9'(w.status));
        end
      end
    end
  end

  task automatic send_word(logic [1:0] op, logic [7:0] idx, bit known = 1'b0,
                           logic [2:0] want_status = '0, logic [8:0] want_count = '0);
    tuple_word_t w;
    cfg_we <= 1'b0;
    while ($urandom_range(99) < src_idle) begin
      cmd.valid <= 1'b0;
      @(posedge clk);
      cfg_we <= 1'b0;
    end
    cmd.valid       <= 1'b1;
    cmd.operation   <= op;
    cmd.state_index <= idx;
    do @(posedge clk); while (!cmd.ready);
    if (predict_word(op, idx, w)) begin
      if (known) begin
        w.status      = want_status;
        w.state_count = want_count;
      end
      pending_words.push_back(w);
    end
  endtask

  // drain all responses, then give the block time to settle
  task automatic wait_quiet();
    cmd.valid <= 1'b0;
    cfg_we    <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // hold the write enable; the next send or drain drops it
  task automatic write_reg(logic [1:0] index, logic [5:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    case (index)
      tbqn_pkg::REG_SHELL:  lim_shell  = int'(value[4:0]);
      tbqn_pkg::REG_RADIAL: lim_radial = int'(value[3:0]);
      tbqn_pkg::REG_ORBIT:  lim_orbit  = int'(value[4:0]);
      default:              lim_pair   = int'(value);
    endcase
  endtask

  row_t directed [] = '{
    '{1'b0, tbqn_pkg::OP_NEXT,    8'd0,   1, 1'b1, tbqn_pkg::ST_EXHAUSTED, 9'd0},
    '{1'b0, tbqn_pkg::OP_LOOKUP,  8'd0,   1, 1'b1, tbqn_pkg::ST_RANGE,     9'd0},
    '{1'b0, tbqn_pkg::OP_UNUSED,  8'hAA,  1, 1'b0, 3'd0,                   9'd0},
    '{1'b0, tbqn_pkg::OP_RESTART, 8'h55,  1, 1'b1, tbqn_pkg::ST_BUILT,     9'd15},
    '{1'b0, tbqn_pkg::OP_LOOKUP,  8'd0,   1, 1'b0, 3'd0,                   9'd0},
    '{1'b0, tbqn_pkg::OP_LOOKUP,  8'd14,  1, 1'b0, 3'd0,                   9'd0},
    '{1'b0, tbqn_pkg::OP_LOOKUP,  8'd15,  1, 1'b1, tbqn_pkg::ST_RANGE,     9'd15},
    '{1'b0, tbqn_pkg::OP_LOOKUP,  8'd255, 1, 1'b1, tbqn_pkg::ST_RANGE,     9'd15},
    '{1'b0, tbqn_pkg::OP_NEXT,    8'd0,   3, 1'b0, 3'd0,                   9'd0},
    '{1'b1, tbqn_pkg::REG_SHELL,  8'd0,   1, 1'b0, 3'd0,                   9'd0},
    '{1'b0, tbqn_pkg::OP_RESTART, 8'd0,   1, 1'b1, tbqn_pkg::ST_BUILT,     9'd1},
    '{1'b0, tbqn_pkg::OP_NEXT,    8'd0,   8, 1'b0, 3'd0,                   9'd0},
    '{1'b0, tbqn_pkg::OP_NEXT,    8'd0,   1, 1'b1, tbqn_pkg::ST_EXHAUSTED, 9'd1},
    '{1'b1, tbqn_pkg::REG_SHELL,  8'd20,  1, 1'b0, 3'd0,                   9'd0},
    '{1'b0, tbqn_pkg::OP_RESTART, 8'd0,   1, 1'b1, tbqn_pkg::ST_BUILT,     9'd231},
    '{1'b0, tbqn_pkg::OP_LOOKUP,  8'd230, 1, 1'b0, 3'd0,                   9'd0},
    '{1'b0, tbqn_pkg::OP_LOOKUP,  8'd231, 1, 1'b1, tbqn_pkg::ST_RANGE,     9'd231},
    '{1'b1, tbqn_pkg::REG_PAIR,   8'd0,   1, 1'b0, 3'd0,                   9'd0},
    '{1'b0, tbqn_pkg::OP_RESTART, 8'd0,   1, 1'b1, tbqn_pkg::ST_BUILT,     9'd231},
    '{1'b0, tbqn_pkg::OP_NEXT,    8'd0,   8, 1'b0, 3'd0,                   9'd0},
    '{1'b0, tbqn_pkg::OP_NEXT,    8'd0,   1, 1'b1, tbqn_pkg::ST_EXHAUSTED, 9'd231},
    '{1'b1, tbqn_pkg::REG_RADIAL, 8'd0,   1, 1'b0, 3'd0,                   9'd0},
    '{1'b1, tbqn_pkg::REG_ORBIT,  8'd0,   1, 1'b0, 3'd0,                   9'd0},
    '{1'b1, tbqn_pkg::REG_PAIR,   8'd63,  1, 1'b0, 3'd0,                   9'd0},
    '{1'b0, tbqn_pkg::OP_RESTART, 8'd0,   1, 1'b1, tbqn_pkg::ST_BUILT,     9'd1},
    '{1'b0, tbqn_pkg::OP_NEXT,    8'd0,   2, 1'b0, 3'd0,                   9'd0}
  };

  initial begin
    int mode, round, n, pick, hi_idx;
    rst             = 1'b1;
    cmd.valid       = 1'b0;
    cmd.operation   = tbqn_pkg::OP_RESTART;
    cmd.state_index = '0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    src_idle = 0; snk_idle = 0;
    lim_shell = 4; lim_radial = 15; lim_orbit = 31; lim_pair = 63;
    n_states = 0; b1 = 0; b2 = 0; k1 = 0; k2 = 0; jv = 0; iso_step = 0;
    walk_over = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        wait_quiet();
        write_reg(directed[i].code, directed[i].arg[5:0]);
      end else begin
        repeat (directed[i].reps)
          send_word(directed[i].code, directed[i].arg, directed[i].known,
                    directed[i].want_status, directed[i].want_count);
      end
    end

    for (mode = 0; mode < 3; mode++) begin
      src_idle = (mode == 0) ? 22 : (mode == 1) ? 49 : 0;
      snk_idle = (mode == 0) ? 49 : (mode == 1) ? 22 : 0;
      for (round = 0; round < 9; round++) begin
        wait_quiet();
        if (round == 0 || $urandom_range(1))
          write_reg(tbqn_pkg::REG_SHELL, 6'($urandom_range(7)));
        if (round == 0 || $urandom_range(1))
          write_reg(tbqn_pkg::REG_RADIAL,
                    6'($urandom_range(1) ? 15 : $urandom_range(15)));
        if (round == 0 || $urandom_range(1))
          write_reg(tbqn_pkg::REG_ORBIT,
                    6'($urandom_range(1) ? 31 : $urandom_range(31)));
        // the pair limit is read live, so it also lands mid-walk
        if (round == 0 || $urandom_range(1))
          write_reg(tbqn_pkg::REG_PAIR,
                    6'(($urandom_range(9) < 3) ? 63 : $urandom_range(20)));
        if (round == 0 || $urandom_range(9) < 6)
          send_word(tbqn_pkg::OP_RESTART, 8'($urandom_range(255)));
        for (n = 0; n < 19; n++) begin
          pick = $urandom_range(99);
          if (pick < 70) begin
            send_word(tbqn_pkg::OP_NEXT, 8'($urandom_range(255)));
          end else if (pick < 85) begin
            hi_idx = (n_states + 2 > 255) ? 255 : n_states + 2;
            send_word(tbqn_pkg::OP_LOOKUP,
                      8'($urandom_range(1) ? $urandom_range(hi_idx)
                                           : $urandom_range(255)));
          end else if (pick < 93) begin
            send_word(tbqn_pkg::OP_RESTART, 8'($urandom_range(255)));
          end else begin
            send_word(tbqn_pkg::OP_UNUSED, 8'($urandom_range(255)));
          end
        end
      end
    end

    wait_quiet();
    if (errors == 0) begin
      $display("two_body_quantum_number_enumerator verification clean");
    end else begin
      $display("two_body_quantum_number_enumerator verification failed");
    end
    $finish;
  end
endmodule
